FILE: sv/varint_group_codec_unit_defines.svh
// Assertion macros shared by the varint group codec RTL.
`ifndef VARINT_GROUP_CODEC_UNIT_DEFINES_SVH
`define VARINT_GROUP_CODEC_UNIT_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define VGC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("vgc assertion failed");
// Next-cycle implication, disabled during reset.
`define VGC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("vgc assertion failed");
`else
`define VGC_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define VGC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: sv/vgc_pkg.sv
// Types and constants shared by the varint group codec modules.
package vgc_pkg;

	localparam int unsigned VALUE_WIDTH_DEF = 64;

	localparam int unsigned S_TDATA_W  = 72;
	localparam int unsigned S_BYTE_LSB = 64;
	localparam int unsigned M_TDATA_W  = 80;

	localparam logic [2:0] GROUP_BITS_RST = 3'd7;
	localparam logic [2:0] GROUP_BITS_6   = 3'd6;

	typedef enum logic {
		MODE_ENCODE = 1'b0,
		MODE_DECODE = 1'b1
	} mode_t;

	typedef enum logic {
		KIND_BYTE  = 1'b0,
		KIND_VALUE = 1'b1
	} kind_t;

	typedef enum logic {
		SHIFT_LEFT  = 1'b0,
		SHIFT_RIGHT = 1'b1
	} shift_dir_t;

	// Control for the shared shifter.
	typedef struct packed {
		shift_dir_t  dir;
		logic [6:0]  amount;
	} shift_ctl_t;

endpackage

FILE: sv/varint_group_codec_unit.sv
// Unsigned varint (LEB128 style) codec with 7- or 6-bit groups, least significant group first.
//
// Encode (tuser 0): one value gives its run of bytes, one byte per cycle while the output
// accepts, the final one with tlast; the continuation flag sits at bit group_bits. The input
// is held off for the whole run of N bytes (N up to ceil(VALUE_WIDTH/g)), paced by the single
// shared shifter that strips one group per byte. Decode (tuser 1): one byte per cycle while
// the output accepts; a byte that still carries the flag produces nothing, a byte
// without it (or the byte that hits the group limit) produces one transaction holding the
// value and byte count, with too_long set when the limit was hit with the flag still up.
// Decode state survives an interleaved encode. The user must write group_bits only while the
// block is idle, via cfg_wr_en / cfg_wr_data (not enforced); any value other than 6 acts as 7.
module varint_group_codec_unit import vgc_pkg::*; #(
	parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [2:0]           cfg_wr_data,   // group_bits
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,  // value_in[63:0], byte_in[71:64]
	input  logic                 s_axis_tuser,  // mode
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata,  // byte_out[7:0], value_out[71:8],
	                                            // byte_count[75:72], too_long[76], zero
	output logic                 m_axis_tuser,  // kind
	output logic                 m_axis_tlast   // last
);

	`include "varint_group_codec_unit_defines.svh"

	// byte limit per group size: ceil(VALUE_WIDTH / g)
	localparam logic [3:0] LIMIT6 = 4'((VALUE_WIDTH + 5) / 6);
	localparam logic [3:0] LIMIT7 = 4'((VALUE_WIDTH + 6) / 7);

	typedef enum logic {
		ST_IDLE,
		ST_ENC
	} state_t;

	state_t                 state_q;
	logic [2:0]             group_bits_q;
	logic [VALUE_WIDTH-1:0] enc_val_q;     // remaining encode value
	logic [VALUE_WIDTH-1:0] partial_q;     // decode accumulator
	logic [3:0]             groups_q;      // decode bytes gathered

	// output register
	logic                   m_valid_q;
	kind_t                  out_kind_q;
	logic [7:0]             out_byte_q;
	logic [63:0]            out_value_q;
	logic [3:0]             out_count_q;
	logic                   out_too_long_q;
	logic                   out_last_q;

	logic                   g6;
	logic [2:0]             grp;
	logic [7:0]             pay_mask;
	logic [7:0]             flag_bit;
	logic [3:0]             limit;

	shift_ctl_t             sh_ctl;
	logic [VALUE_WIDTH-1:0] sh_operand;
	logic [VALUE_WIDTH-1:0] sh_result;

	logic [7:0]             din_byte;
	logic                   dec_flag;
	logic [VALUE_WIDTH-1:0] dec_value;
	logic [3:0]             dec_n1;
	logic                   dec_done;

	logic [7:0]             enc_byte;
	logic                   enc_more;

	logic                   out_free;
	logic                   out_load;
	logic                   in_acc;

	assign g6       = (group_bits_q == GROUP_BITS_6);
	assign grp      = g6 ? 3'd6 : 3'd7;
	assign pay_mask = g6 ? 8'h3F : 8'h7F;
	assign flag_bit = g6 ? 8'h40 : 8'h80;
	assign limit    = g6 ? LIMIT6 : LIMIT7;

	assign din_byte = s_axis_tdata[S_BYTE_LSB +: 8];

	// One shifter, two users: encode strips a group per cycle while the output accepts, decode
	// places the incoming payload at offset groups*g (never both in the same cycle).
	always_comb begin
		if (state_q == ST_ENC) begin
			sh_ctl.dir    = SHIFT_RIGHT;
			sh_ctl.amount = {4'd0, grp};
			sh_operand    = enc_val_q;
		end else begin
			sh_ctl.dir    = SHIFT_LEFT;
			sh_ctl.amount = 7'({3'd0, groups_q} * {4'd0, grp});
			sh_operand    = VALUE_WIDTH'(din_byte & pay_mask);
		end
	end

	vgc_shifter #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_shifter (
		.ctl     (sh_ctl),
		.operand (sh_operand),
		.result  (sh_result)
	);

	// decode step
	assign dec_flag  = |(din_byte & flag_bit);
	assign dec_value = partial_q | sh_result;
	assign dec_n1    = groups_q + 4'd1;
	assign dec_done  = !dec_flag || (dec_n1 >= limit);

	// encode step
	assign enc_more = |sh_result;
	assign enc_byte = (enc_val_q[7:0] & pay_mask) | (enc_more ? flag_bit : 8'h00);

	assign out_free      = !m_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) && out_free;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	// a new result enters the output register this cycle
	assign out_load      = (state_q == ST_ENC) ? out_free
	                       : (in_acc && s_axis_tuser == MODE_DECODE && dec_done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			group_bits_q   <= GROUP_BITS_RST;
			enc_val_q      <= '0;
			partial_q      <= '0;
			groups_q       <= '0;
			m_valid_q      <= 1'b0;
			out_kind_q     <= KIND_BYTE;
			out_byte_q     <= '0;
			out_value_q    <= '0;
			out_count_q    <= '0;
			out_too_long_q <= 1'b0;
			out_last_q     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				group_bits_q <= cfg_wr_data;
			end
			if (m_valid_q && m_axis_tready && !out_load) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (s_axis_tuser == MODE_ENCODE) begin
							enc_val_q <= s_axis_tdata[VALUE_WIDTH-1:0];
							state_q   <= ST_ENC;
						end else if (dec_done) begin
							m_valid_q      <= 1'b1;
							out_kind_q     <= KIND_VALUE;
							out_byte_q     <= '0;
							out_value_q    <= 64'(dec_value);
							out_count_q    <= dec_n1;
							out_too_long_q <= dec_flag;
							out_last_q     <= 1'b1;
							partial_q      <= '0;
							groups_q       <= '0;
						end else begin
							partial_q <= dec_value;
							groups_q  <= dec_n1;
						end
					end
				end
				ST_ENC: begin
					if (out_free) begin
						m_valid_q      <= 1'b1;
						out_kind_q     <= KIND_BYTE;
						out_byte_q     <= enc_byte;
						out_value_q    <= '0;
						out_count_q    <= '0;
						out_too_long_q <= 1'b0;
						out_last_q     <= !enc_more;
						enc_val_q      <= sh_result;
						if (!enc_more) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {3'b000, out_too_long_q, out_count_q, out_value_q, out_byte_q};

	// encode never disturbs a decode run in progress
	`VGC_ASSERT_NEXT(a_enc_keeps_dec, clk, arst_n, state_q == ST_ENC,
		$stable(partial_q) && $stable(groups_q))
	// gathered byte count stays below the largest limit
	`VGC_ASSERT_IMPL(a_groups_bound, clk, arst_n, 1'b1, groups_q < LIMIT6)
	// a decoded value is always the last of its run
	`VGC_ASSERT_IMPL(a_value_last, clk, arst_n,
		m_valid_q && out_kind_q == KIND_VALUE, out_last_q)
	// an overlong run reports exactly the limit
	`VGC_ASSERT_IMPL(a_too_long_count, clk, arst_n,
		m_valid_q && out_too_long_q, out_count_q == limit)
	// non-final encoded bytes carry the continuation flag
	`VGC_ASSERT_IMPL(a_enc_flag, clk, arst_n,
		m_valid_q && out_kind_q == KIND_BYTE && !out_last_q, |(out_byte_q & flag_bit))

endmodule

FILE: sv/vgc_shifter.sv
// Shared shifter: right by the group size for encode, left by the group offset for decode.
module vgc_shifter import vgc_pkg::*; #(
	parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  shift_ctl_t             ctl,
	input  logic [VALUE_WIDTH-1:0] operand,
	output logic [VALUE_WIDTH-1:0] result
);

	// amounts at or above the width yield zero
	always_comb begin
		case (ctl.dir)
			SHIFT_RIGHT: result = operand >> ctl.amount;
			SHIFT_LEFT:  result = operand << ctl.amount;
			default:     result = operand;
		endcase
	end

endmodule
